### sv/plt_pkg.sv
// ----------------------------------------------------------------------------
// plt_pkg: shared definitions for the positional list store
// Operation codes and the control bits that travel along the cell chain.
// ----------------------------------------------------------------------------
package plt_pkg;

	typedef logic [2:0] op_t;

	localparam op_t OP_INSERT = 3'd0;
	localparam op_t OP_DELETE = 3'd1;
	localparam op_t OP_READ   = 3'd2;
	localparam op_t OP_SEARCH = 3'd3;
	localparam op_t OP_FIND   = 3'd4;
	localparam op_t OP_NOP    = 3'd7;

	localparam int POS_W = 7;
	localparam int OUT_W = 32;

	typedef struct packed {
		logic active;
		logic hit;
	} ctl_t;

endpackage

### sv/plt_cell.sv
// ----------------------------------------------------------------------------
// plt_cell: one entry of the positional list store
// Holds one list entry and acts on it when the operation token passes by,
// then hands the token, its carried word, its hit position and its hit state to the next cell.
// ----------------------------------------------------------------------------
module plt_cell #(
	parameter int DATA_WIDTH = 32,
	parameter int CNT_W      = 7,
	parameter int IDX_W      = 6,
	parameter int IDX        = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  plt_pkg::op_t          op,
	input  logic [IDX_W-1:0]      pos,
	input  logic [CNT_W-1:0]      cnt,
	input  logic [DATA_WIDTH-1:0] val,
	input  plt_pkg::ctl_t         ctl_in,
	input  logic [DATA_WIDTH-1:0] carry_in,
	input  logic [CNT_W-1:0]      hpos_in,
	input  logic [DATA_WIDTH-1:0] right_entry,
	output plt_pkg::ctl_t         ctl_out,
	output logic [DATA_WIDTH-1:0] carry_out,
	output logic [CNT_W-1:0]      hpos_out,
	output logic [DATA_WIDTH-1:0] entry_out
);
	import plt_pkg::*;

	logic [DATA_WIDTH-1:0] entry_q;
	logic [DATA_WIDTH-1:0] carry_q;
	logic [CNT_W-1:0]      hpos_q;
	ctl_t                  ctl_q;
	logic [DATA_WIDTH-1:0] next_carry;
	logic [CNT_W-1:0]      next_hpos;
	logic                  next_hit;
	logic                  at_pos;
	logic                  after_pos;

	assign at_pos    = (IDX_W'(IDX) == pos);
	assign after_pos = (IDX_W'(IDX) > pos);

	always_comb begin
		next_carry = carry_in;
		next_hpos  = hpos_in;
		next_hit   = ctl_in.hit;
		if (ctl_in.active) begin
			case (op) inside
				OP_INSERT: begin
					if (at_pos || (after_pos && (CNT_W'(IDX) <= cnt)))
						next_carry = entry_q;
				end
				OP_DELETE, OP_READ: begin
					if (at_pos)
						next_carry = entry_q;
				end
				OP_SEARCH: begin
					if (!ctl_in.hit && (CNT_W'(IDX) < cnt) && (entry_q == val)) begin
						next_hit  = 1'b1;
						next_hpos = CNT_W'(IDX + 1);
					end
				end
				OP_FIND: begin
					if (at_pos)
						next_hit = (entry_q == val);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en && ctl_in.active) begin
			case (op) inside
				OP_INSERT: begin
					if (at_pos)
						entry_q <= val;
					else if (after_pos && (CNT_W'(IDX) <= cnt))
						entry_q <= carry_in;
				end
				OP_DELETE: begin
					if (!(IDX_W'(IDX) < pos) && (CNT_W'(IDX + 1) < cnt))
						entry_q <= right_entry;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			carry_q <= next_carry;
			hpos_q  <= next_hpos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= '{active: ctl_in.active, hit: next_hit};
		end
	end

	assign ctl_out   = ctl_q;
	assign carry_out = carry_q;
	assign hpos_out  = hpos_q;
	assign entry_out = entry_q;

endmodule

### sv/positional_list_store.sv
// ----------------------------------------------------------------------------
// positional_list_store: ordered list with insert, delete, read, search and find
// Top level: request decode, list length, the cell chain and the result
// register.
// ----------------------------------------------------------------------------
// Requests arrive on in_valid/in_ready with operation, position and value;
// one result per request leaves on out_valid/out_ready. The list is a row of
// CAPACITY cells, and each request sends a token from the first cell to the
// last, which shifts, reads and compares on its way, one cell per cycle
// while the chain is not held. The block works on one request at a time,
// and the next request is taken in the cycle after the result is loaded.
// A new request is accepted as soon as the previous token has left the
// chain, even while its result still waits in the output register. If the
// receiver stalls when a token reaches the end of the chain, the whole
// chain holds until the result register is free. Requests that are refused
// (full list, position out of range, unknown operation) still send their
// token along the chain and leave the list unchanged. Reset empties the
// list; no clearing pass is needed.
// ----------------------------------------------------------------------------
module positional_list_store #(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  plt_pkg::op_t                 operation,
	input  logic [plt_pkg::POS_W-1:0]    position,
	input  logic [plt_pkg::OUT_W-1:0]    value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [plt_pkg::OUT_W-1:0]    data_out,
	output logic [plt_pkg::POS_W-1:0]    found_position,
	output logic                         match,
	output logic [plt_pkg::POS_W-1:0]    list_length,
	output logic                         empty_res,
	output logic                         error
);
	import plt_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      old_cnt_q;
	op_t                   op_q;
	logic [IDX_W-1:0]      pos_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic                  err_q;
	logic                  busy_q;
	logic                  start_q;

	logic                  out_valid_q;
	logic [OUT_W-1:0]      data_q;
	logic [POS_W-1:0]      fpos_q;
	logic                  match_q;
	logic [POS_W-1:0]      len_q;
	logic                  empty_q;
	logic                  error_q;

	logic [CMP_W-1:0]      pos_w;
	logic [CMP_W-1:0]      cnt_w;
	logic                  req_err;
	logic                  accept;
	logic                  en;
	logic                  exit_fire;

	ctl_t                  ctl_c   [CAPACITY+1];
	logic [DATA_WIDTH-1:0] carry_c [CAPACITY+1];
	logic [CNT_W-1:0]      hpos_c  [CAPACITY+1];
	logic [DATA_WIDTH-1:0] entry_c [CAPACITY+1];
	logic [CAPACITY-1:0]   act_vec;

	assign in_ready = !busy_q;
	assign accept   = in_valid && in_ready;
	assign pos_w    = CMP_W'(position);
	assign cnt_w    = CMP_W'(count_q);

	always_comb begin
		unique case (operation) inside
			OP_INSERT:         req_err = (count_q == CNT_W'(CAPACITY)) || (pos_w > cnt_w);
			OP_DELETE, OP_READ: req_err = (pos_w >= cnt_w);
			OP_SEARCH:         req_err = 1'b0;
			OP_FIND:           req_err = (pos_w == '0) || (pos_w > cnt_w);
			default:           req_err = 1'b1;
		endcase
	end

	assign en        = !(ctl_c[CAPACITY].active && out_valid_q && !out_ready);
	assign exit_fire = ctl_c[CAPACITY].active && en;

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= req_err ? OP_NOP : operation;
			pos_q     <= (operation == OP_FIND) ? IDX_W'(pos_w - CMP_W'(1)) : IDX_W'(pos_w);
			val_q     <= DATA_WIDTH'(value);
			old_cnt_q <= count_q;
			err_q     <= req_err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			busy_q  <= 1'b0;
			start_q <= 1'b0;
		end else begin
			if (accept && !req_err) begin
				if (operation == OP_INSERT)
					count_q <= count_q + CNT_W'(1);
				else if (operation == OP_DELETE)
					count_q <= count_q - CNT_W'(1);
			end
			if (accept)
				busy_q <= 1'b1;
			else if (exit_fire)
				busy_q <= 1'b0;
			if (accept)
				start_q <= 1'b1;
			else if (en)
				start_q <= 1'b0;
		end
	end

	assign ctl_c[0]   = '{active: start_q, hit: 1'b0};
	assign carry_c[0] = '0;
	assign hpos_c[0]  = '0;
	assign entry_c[CAPACITY] = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		plt_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.CNT_W      (CNT_W),
			.IDX_W      (IDX_W),
			.IDX        (i)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.en          (en),
			.op          (op_q),
			.pos         (pos_q),
			.cnt         (old_cnt_q),
			.val         (val_q),
			.ctl_in      (ctl_c[i]),
			.carry_in    (carry_c[i]),
			.hpos_in     (hpos_c[i]),
			.right_entry (entry_c[i+1]),
			.ctl_out     (ctl_c[i+1]),
			.carry_out   (carry_c[i+1]),
			.hpos_out    (hpos_c[i+1]),
			.entry_out   (entry_c[i])
		);
		assign act_vec[i] = ctl_c[i+1].active;
	end

	always_ff @(posedge clk) begin
		if (exit_fire) begin
			data_q  <= ((op_q == OP_READ) || (op_q == OP_DELETE)) ?
				OUT_W'(carry_c[CAPACITY]) : '0;
			fpos_q  <= (op_q == OP_SEARCH) ? POS_W'(hpos_c[CAPACITY]) : '0;
			match_q <= ((op_q == OP_SEARCH) || (op_q == OP_FIND)) && ctl_c[CAPACITY].hit;
			len_q   <= POS_W'(count_q);
			empty_q <= (count_q == '0);
			error_q <= err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exit_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign data_out       = data_q;
	assign found_position = fpos_q;
	assign match          = match_q;
	assign list_length    = len_q;
	assign empty_res      = empty_q;
	assign error          = error_q;

`ifndef SYNTHESIS
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({start_q, act_vec}))
		else $error("More than one token in the cell chain.");

	a_exit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		exit_fire |-> busy_q)
		else $error("Token left the chain with no item in flight.");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("List length exceeds capacity.");

	a_error_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && error) |-> (data_out == '0 && !match && found_position == '0))
		else $error("Refused item reported data.");
`endif

endmodule
